FILE: rtl/core/jdqt_pkg.sv
// Shared constants and the zigzag de-scan table for the DQT segment parser.
package jdqt_pkg;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_DQT    = 8'hDB;

    // Result kinds as carried on m_kind.
    localparam logic KIND_ENTRY     = 1'b0;
    localparam logic KIND_LEN_ERROR = 1'b1;

    localparam int unsigned TABLE_BYTES  = 65;
    localparam int unsigned TABLE_VALUES = 64;
    localparam int unsigned IDX_W        = $clog2(TABLE_VALUES);
    localparam int unsigned COUNT_W      = 10;

    localparam logic [15:0] MIN_LENGTH = 16'd2;

    // floor(x / 65) equals (x * DIV65_MUL) >> DIV65_SHIFT for every 16-bit x.
    localparam int unsigned DIV65_SHIFT = 23;
    localparam logic [16:0] DIV65_MUL   =
        17'(((64'd1 << DIV65_SHIFT) + TABLE_BYTES - 1) / TABLE_BYTES);

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_VALUES - 1);

    typedef logic [IDX_W-1:0] zz_index_t;

    // Natural 8x8 position (row*8+col) of the coefficient at a zigzag index.
    function automatic zz_index_t natural_of_zigzag(input zz_index_t zz);
        zz_index_t pos;
        case (zz)
            6'd0:  pos = 6'd0;   6'd1:  pos = 6'd1;   6'd2:  pos = 6'd8;   6'd3:  pos = 6'd16;
            6'd4:  pos = 6'd9;   6'd5:  pos = 6'd2;   6'd6:  pos = 6'd3;   6'd7:  pos = 6'd10;
            6'd8:  pos = 6'd17;  6'd9:  pos = 6'd24;  6'd10: pos = 6'd32;  6'd11: pos = 6'd25;
            6'd12: pos = 6'd18;  6'd13: pos = 6'd11;  6'd14: pos = 6'd4;   6'd15: pos = 6'd5;
            6'd16: pos = 6'd12;  6'd17: pos = 6'd19;  6'd18: pos = 6'd26;  6'd19: pos = 6'd33;
            6'd20: pos = 6'd40;  6'd21: pos = 6'd48;  6'd22: pos = 6'd41;  6'd23: pos = 6'd34;
            6'd24: pos = 6'd27;  6'd25: pos = 6'd20;  6'd26: pos = 6'd13;  6'd27: pos = 6'd6;
            6'd28: pos = 6'd7;   6'd29: pos = 6'd14;  6'd30: pos = 6'd21;  6'd31: pos = 6'd28;
            6'd32: pos = 6'd35;  6'd33: pos = 6'd42;  6'd34: pos = 6'd49;  6'd35: pos = 6'd56;
            6'd36: pos = 6'd57;  6'd37: pos = 6'd50;  6'd38: pos = 6'd43;  6'd39: pos = 6'd36;
            6'd40: pos = 6'd29;  6'd41: pos = 6'd22;  6'd42: pos = 6'd15;  6'd43: pos = 6'd23;
            6'd44: pos = 6'd30;  6'd45: pos = 6'd37;  6'd46: pos = 6'd44;  6'd47: pos = 6'd51;
            6'd48: pos = 6'd58;  6'd49: pos = 6'd59;  6'd50: pos = 6'd52;  6'd51: pos = 6'd45;
            6'd52: pos = 6'd38;  6'd53: pos = 6'd31;  6'd54: pos = 6'd39;  6'd55: pos = 6'd46;
            6'd56: pos = 6'd53;  6'd57: pos = 6'd60;  6'd58: pos = 6'd61;  6'd59: pos = 6'd54;
            6'd60: pos = 6'd47;  6'd61: pos = 6'd55;  6'd62: pos = 6'd62;  6'd63: pos = 6'd63;
            default: pos = zz;
        endcase
        return pos;
    endfunction

endpackage

FILE: rtl/core/jpeg_dqt_segment_parser.sv
// DQT segment parser: finds FF DB, checks the length and emits de-scanned table entries.
// Path: an accepted byte is held in the input register, and its result, if any, is then
// written to the result register, which drives the result outputs.
// Throughput: one byte per cycle; a byte stalls only while the result register still holds
// an untaken result, and then the input register takes one more byte before s_ready drops.
// Reset: aresetn is synchronous and active low; it empties both registers and puts the
// parser back to scanning for the marker with all counters cleared.
module jpeg_dqt_segment_parser (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_stream_end,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [3:0] m_table_id,
    output logic [3:0] m_precision,
    output logic [5:0] m_position,
    output logic [7:0] m_value,
    output logic       m_last_of_table
);

    // Parse phases. Codes outside the list behave as scanning.
    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_INFO   = 3'd3,
        PH_VALUES = 3'd4
    } phase_t;

    localparam int unsigned IDX_W   = jdqt_pkg::IDX_W;
    localparam int unsigned COUNT_W = jdqt_pkg::COUNT_W;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_end_reg,   in_end_next;

    // Parser state.
    phase_t             phase_reg,      phase_next;
    logic               seen_ff_reg,    seen_ff_next;
    logic [7:0]         len_hi_reg,     len_hi_next;
    logic [COUNT_W-1:0] tables_reg,     tables_next;
    logic [IDX_W-1:0]   index_reg,      index_next;
    logic [3:0]         cur_id_reg,     cur_id_next;
    logic [3:0]         cur_prec_reg,   cur_prec_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic             kind_reg,      kind_next;
    logic [3:0]       id_reg,        id_next;
    logic [3:0]       prec_reg,      prec_next;
    logic [IDX_W-1:0] pos_reg,       pos_next;
    logic [7:0]       value_reg,     value_next;
    logic             last_reg,      last_next;

    // The byte in the input register is processed in the cycle where the result
    // register is free or is being emptied; bytes with no result still pass here.
    logic advance;
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Segment length check. The length minus two must be a multiple of 65; the
    // quotient comes from a reciprocal multiply and the remainder from a shift-add.
    logic [15:0]        len_full;
    logic [15:0]        len_minus2;
    logic [32:0]        div_product;
    logic [COUNT_W-1:0] table_count;
    logic [15:0]        count_times65;
    logic [15:0]        len_rem;
    logic               length_ok;

    assign len_full      = {len_hi_reg, in_byte_reg};
    assign len_minus2    = len_full - jdqt_pkg::MIN_LENGTH;
    assign div_product   = 33'(len_minus2) * 33'(jdqt_pkg::DIV65_MUL);
    assign table_count   = div_product[jdqt_pkg::DIV65_SHIFT +: COUNT_W];
    assign count_times65 = {table_count, 6'd0} + 16'(table_count);
    assign len_rem       = len_minus2 - count_times65;
    assign length_ok     = (len_full >= jdqt_pkg::MIN_LENGTH) && (len_rem == 16'd0);

    logic               last_value;
    logic [COUNT_W-1:0] tables_dec;

    assign last_value = (index_reg == jdqt_pkg::LAST_INDEX);
    assign tables_dec = tables_reg - COUNT_W'(1);

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_end_next    = in_end_reg;

        phase_next     = phase_reg;
        seen_ff_next   = seen_ff_reg;
        len_hi_next    = len_hi_reg;
        tables_next    = tables_reg;
        index_next     = index_reg;
        cur_id_next    = cur_id_reg;
        cur_prec_next  = cur_prec_reg;

        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        id_next        = id_reg;
        prec_next      = prec_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        if (advance) begin
            unique case (phase_reg)
                PH_LEN_HI: begin
                    len_hi_next = in_byte_reg;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    seen_ff_next = 1'b0;
                    if (!length_ok) begin
                        // Length error: a result with every field but kind cleared.
                        out_valid_next = 1'b1;
                        kind_next      = jdqt_pkg::KIND_LEN_ERROR;
                        id_next        = 4'd0;
                        prec_next      = 4'd0;
                        pos_next       = '0;
                        value_next     = 8'd0;
                        last_next      = 1'b0;
                        phase_next     = PH_SCAN;
                    end else begin
                        tables_next = table_count;
                        phase_next  = (table_count == '0) ? PH_SCAN : PH_INFO;
                    end
                end
                PH_INFO: begin
                    cur_prec_next = in_byte_reg[7:4];
                    cur_id_next   = in_byte_reg[3:0];
                    index_next    = '0;
                    phase_next    = PH_VALUES;
                end
                PH_VALUES: begin
                    out_valid_next = 1'b1;
                    kind_next      = jdqt_pkg::KIND_ENTRY;
                    id_next        = cur_id_reg;
                    prec_next      = cur_prec_reg;
                    pos_next       = jdqt_pkg::natural_of_zigzag(index_reg);
                    value_next     = in_byte_reg;
                    last_next      = last_value;
                    if (last_value) begin
                        index_next   = '0;
                        tables_next  = tables_dec;
                        phase_next   = (tables_dec == '0) ? PH_SCAN : PH_INFO;
                        seen_ff_next = 1'b0;
                    end else begin
                        index_next = index_reg + IDX_W'(1);
                    end
                end
                default: begin
                    // Scanning: FF followed by DB opens a segment; runs of FF keep
                    // the prefix armed.
                    if (seen_ff_reg && in_byte_reg == jdqt_pkg::MARKER_DQT) begin
                        phase_next   = PH_LEN_HI;
                        seen_ff_next = 1'b0;
                    end else begin
                        phase_next   = PH_SCAN;
                        seen_ff_next = (in_byte_reg == jdqt_pkg::MARKER_PREFIX);
                    end
                end
            endcase

            // The last byte of a file drops any open segment.
            if (in_end_reg) begin
                phase_next   = PH_SCAN;
                seen_ff_next = 1'b0;
                tables_next  = '0;
                index_next   = '0;
            end
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_byte_in;
            in_end_next   = s_stream_end;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SCAN;
            seen_ff_reg   <= 1'b0;
            len_hi_reg    <= 8'd0;
            tables_reg    <= '0;
            index_reg     <= '0;
            cur_id_reg    <= 4'd0;
            cur_prec_reg  <= 4'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            seen_ff_reg   <= seen_ff_next;
            len_hi_reg    <= len_hi_next;
            tables_reg    <= tables_next;
            index_reg     <= index_next;
            cur_id_reg    <= cur_id_next;
            cur_prec_reg  <= cur_prec_next;
        end
        in_byte_reg <= in_byte_next;
        in_end_reg  <= in_end_next;
        kind_reg    <= kind_next;
        id_reg      <= id_next;
        prec_reg    <= prec_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = kind_reg;
    assign m_table_id      = id_reg;
    assign m_precision     = prec_reg;
    assign m_position      = pos_reg;
    assign m_value         = value_reg;
    assign m_last_of_table = last_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the DQT segment parser: directed, pressure and random streams.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned COUNT_W = jdqt_pkg::COUNT_W;

    // Parser phases of the testbench's own copy of the parser.
    typedef enum logic [2:0] {
        SEEK_MARKER,
        LEN_HIGH,
        LEN_LOW,
        TABLE_INFO,
        TABLE_VALUES
    } parse_phase_t;

    // One result as the block reports it.
    typedef struct packed {
        logic       kind;
        logic [3:0] table_id;
        logic [3:0] precision;
        logic [5:0] position;
        logic [7:0] value;
        logic       last_of_table;
    } dqt_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_byte_in;
    logic       s_stream_end;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic [3:0] m_table_id;
    logic [3:0] m_precision;
    logic [5:0] m_position;
    logic [7:0] m_value;
    logic       m_last_of_table;

    jpeg_dqt_segment_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_stream_end    (s_stream_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_table_id      (m_table_id),
        .m_precision     (m_precision),
        .m_position      (m_position),
        .m_value         (m_value),
        .m_last_of_table (m_last_of_table)
    );

    // Results that the byte stream accepted so far must still produce, oldest first.
    dqt_result_t pending_dqt_results[$];

    // The testbench's own copy of the parser state.
    parse_phase_t         parse_state;
    logic                 marker_half;
    logic [15:0]          seg_length;
    logic [COUNT_W-1:0]   tables_remaining;
    logic [5:0]           coef_index;
    logic [3:0]           cur_table_id;
    logic [3:0]           cur_precision;

    // Natural 8x8 position of each zigzag index, built once at time zero.
    logic [5:0]           zigzag_pos[jdqt_pkg::TABLE_VALUES];

    int unsigned error_count;
    int unsigned bytes_sent;

    // Idling controls. The sink hold request asks the result side to stall for a
    // long stretch; the sink process counts it down on its own.
    bit          src_idle_on;
    bit          sink_idle_on;
    int unsigned sink_hold_request;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Walk the anti-diagonals of the 8x8 block. Odd diagonals run down-left and
    // even diagonals run up-right, which gives the standard zigzag scan.
    initial begin : build_zigzag
        int idx;
        int s;
        int r;
        idx = 0;
        for (s = 0; s < 15; s++) begin
            if (s % 2 == 1) begin
                for (r = (s > 7 ? s - 7 : 0); r <= (s < 7 ? s : 7); r++) begin
                    zigzag_pos[idx] = 6'(r * 8 + (s - r));
                    idx++;
                end
            end else begin
                for (r = (s < 7 ? s : 7); r >= (s > 7 ? s - 7 : 0); r--) begin
                    zigzag_pos[idx] = 6'(r * 8 + (s - r));
                    idx++;
                end
            end
        end
    end

    // Advance the predicted parser by one accepted byte and queue the result that
    // the byte causes, if any.
    task automatic parse_dqt_byte(input logic [7:0] data, input logic last_byte);
        dqt_result_t res;
        res = '0;
        case (parse_state)
            LEN_HIGH: begin
                seg_length  = {data, 8'h00};
                parse_state = LEN_LOW;
            end
            LEN_LOW: begin
                seg_length[7:0] = data;
                if (seg_length < jdqt_pkg::MIN_LENGTH ||
                        ((seg_length - jdqt_pkg::MIN_LENGTH) % jdqt_pkg::TABLE_BYTES) != 0) begin
                    // A bad length reports an error with all other fields zero.
                    res.kind = jdqt_pkg::KIND_LEN_ERROR;
                    pending_dqt_results.push_back(res);
                    parse_state = SEEK_MARKER;
                end else begin
                    tables_remaining = COUNT_W'((seg_length - jdqt_pkg::MIN_LENGTH)
                                                / jdqt_pkg::TABLE_BYTES);
                    parse_state = (tables_remaining == 0) ? SEEK_MARKER : TABLE_INFO;
                end
                marker_half = 1'b0;
            end
            TABLE_INFO: begin
                cur_precision = data[7:4];
                cur_table_id  = data[3:0];
                coef_index    = '0;
                parse_state   = TABLE_VALUES;
            end
            TABLE_VALUES: begin
                res.kind          = jdqt_pkg::KIND_ENTRY;
                res.table_id      = cur_table_id;
                res.precision     = cur_precision;
                res.position      = zigzag_pos[coef_index];
                res.value         = data;
                res.last_of_table = (coef_index == 6'(jdqt_pkg::TABLE_VALUES - 1));
                pending_dqt_results.push_back(res);
                if (res.last_of_table) begin
                    coef_index       = '0;
                    tables_remaining = tables_remaining - 1'b1;
                    parse_state      = (tables_remaining == 0) ? SEEK_MARKER : TABLE_INFO;
                    marker_half      = 1'b0;
                end else begin
                    coef_index = coef_index + 1'b1;
                end
            end
            default: begin
                // A prefix byte followed by the DQT code opens a segment; repeated
                // prefix bytes keep the match armed.
                if (marker_half && data == jdqt_pkg::MARKER_DQT) begin
                    parse_state = LEN_HIGH;
                    marker_half = 1'b0;
                end else begin
                    parse_state = SEEK_MARKER;
                    marker_half = (data == jdqt_pkg::MARKER_PREFIX);
                end
            end
        endcase

        // The last byte of a file is handled as usual and then drops any segment.
        if (last_byte) begin
            parse_state      = SEEK_MARKER;
            marker_half      = 1'b0;
            tables_remaining = '0;
            coef_index       = '0;
        end
    endtask

    // Offer one byte, optionally after a random gap, and wait for its transfer.
    // Valid stays high between back-to-back bytes, so it gets one assignment per step.
    task automatic send_byte(input logic [7:0] data, input logic last_byte);
        int unsigned gap;
        if (src_idle_on && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_in    <= data;
        s_stream_end <= last_byte;
        do @(posedge aclk); while (s_ready !== 1'b1);
        parse_dqt_byte(data, last_byte);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every predicted result has been seen.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_dqt_results.size() != 0) @(posedge aclk);
    endtask

    // Send a marker, a length and a body of random bytes. With end_on_last the
    // final byte sent (the length low byte when the body is empty) ends the file.
    task automatic send_dqt_segment(input logic [15:0] len_field, input int unsigned body_len,
                                    input bit end_on_last);
        int unsigned k;
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        if ($urandom_range(0, 3) == 0) send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        send_byte(len_field[15:8], 1'b0);
        send_byte(len_field[7:0], end_on_last && body_len == 0);
        for (k = 0; k < body_len; k++) begin
            send_byte(8'($urandom_range(0, 255)), end_on_last && k == body_len - 1);
        end
    endtask

    // Random filler between segments, biased toward marker bytes so that partial
    // and broken markers show up often.
    task automatic send_noise(input int unsigned count);
        int unsigned k;
        int unsigned pick;
        logic [7:0]  data;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 7);
            if (pick < 2) data = jdqt_pkg::MARKER_PREFIX;
            else if (pick == 2) data = jdqt_pkg::MARKER_DQT;
            else data = 8'($urandom_range(0, 255));
            send_byte(data, $urandom_range(0, 15) == 0);
        end
    endtask

    // Marker recognition: a lone DQT code, a broken pair, and a doubled prefix.
    task automatic test_marker_scan();
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        // The doubled prefix still matches; length zero is below two and fails.
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_for_drain();
    endtask

    // Length checks: one below the minimum, exactly the minimum with no tables,
    // the largest field value, and a length just past one whole table.
    task automatic test_length_checks();
        send_dqt_segment(16'h0001, 0, 1'b0);
        send_dqt_segment(jdqt_pkg::MIN_LENGTH, 0, 1'b0);
        send_dqt_segment(16'hFFFF, 0, 1'b0);
        send_dqt_segment(16'(jdqt_pkg::MIN_LENGTH + jdqt_pkg::TABLE_BYTES + 1), 0, 1'b0);
        wait_for_drain();
    endtask

    // End of file inside a table, on a lone prefix byte, and on a length byte.
    task automatic test_stream_end();
        // The cut byte is still emitted, then the rest of the segment is dropped.
        send_dqt_segment(16'(jdqt_pkg::MIN_LENGTH + jdqt_pkg::TABLE_BYTES), 4, 1'b1);
        send_byte(8'h11, 1'b0);
        // A prefix at the end of one file must not pair with a code in the next.
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b1);
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        // The error on a bad length is still reported when that byte ends the file.
        send_dqt_segment(16'h0000, 0, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_for_drain();
    endtask

    // Two full tables with extreme info nibbles while the result side stalls for a
    // long stretch. The sender keeps offering bytes, so the parser fills and pushes
    // back on its input.
    task automatic test_full_table_backpressure();
        int unsigned t;
        int unsigned k;
        src_idle_on       = 1'b0;
        sink_idle_on      = 1'b0;
        sink_hold_request = 80;
        send_byte(jdqt_pkg::MARKER_PREFIX, 1'b0);
        send_byte(jdqt_pkg::MARKER_DQT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'(jdqt_pkg::MIN_LENGTH + 2 * jdqt_pkg::TABLE_BYTES), 1'b0);
        for (t = 0; t < 2; t++) begin
            send_byte((t == 0) ? 8'h0F : 8'hF0, 1'b0);
            for (k = 0; k < jdqt_pkg::TABLE_VALUES; k++) begin
                send_byte((k % 2 == t) ? 8'hFF : 8'h00, 1'b0);
            end
        end
        wait_for_drain();
    endtask

    // Mostly well-formed segments with random content, mixed with bad lengths,
    // empty segments, files cut short inside huge segments, and noise.
    task automatic test_random_streams();
        int unsigned pick;
        int unsigned n_tables;
        int unsigned body_len;
        logic [15:0] len_field;
        while (bytes_sent < 700) begin
            // Idling is switched per segment so that some stretches run flat out.
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 4));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n_tables = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
                send_dqt_segment(16'(jdqt_pkg::MIN_LENGTH + n_tables * jdqt_pkg::TABLE_BYTES),
                                 n_tables * jdqt_pkg::TABLE_BYTES, $urandom_range(0, 7) == 0);
            end else if (pick < 67) begin
                send_dqt_segment(16'($urandom_range(0, 16'hFFFF)), 0, 1'b0);
            end else if (pick < 74) begin
                send_dqt_segment(16'($urandom_range(0, 2)), 0, $urandom_range(0, 3) == 0);
            end else if (pick < 86) begin
                // Up to the largest table count that a 16-bit length can describe.
                n_tables  = $urandom_range(1, 1008);
                len_field = 16'(jdqt_pkg::MIN_LENGTH + n_tables * jdqt_pkg::TABLE_BYTES);
                body_len  = $urandom_range(0, 90);
                send_dqt_segment(len_field, body_len, 1'b1);
            end else begin
                send_noise($urandom_range(1, 10));
            end
        end
        wait_for_drain();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_noise(3);
        send_dqt_segment(16'(jdqt_pkg::MIN_LENGTH + jdqt_pkg::TABLE_BYTES),
                         jdqt_pkg::TABLE_BYTES, 1'b0);
        send_dqt_segment(16'h1234, 0, 1'b0);
        send_dqt_segment(16'(jdqt_pkg::MIN_LENGTH + jdqt_pkg::TABLE_BYTES),
                         jdqt_pkg::TABLE_BYTES, 1'b1);
        wait_for_drain();
    endtask

    // Result side: random stall bursts, plus the long hold-off when a test asks.
    initial begin : sink_driver
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_request != 0) begin
                stall_left        = sink_hold_request;
                sink_hold_request = 0;
            end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin
        dqt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dqt_results.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d value %0d",
                       m_kind, m_value);
                error_count++;
            end else begin
                want = pending_dqt_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(m_kind));
                check_field("table_id", 8'(want.table_id), 8'(m_table_id));
                check_field("precision", 8'(want.precision), 8'(m_precision));
                check_field("position", 8'(want.position), 8'(m_position));
                check_field("value", want.value, m_value);
                check_field("last_of_table", 8'(want.last_of_table), 8'(m_last_of_table));
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #400_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        error_count       = 0;
        bytes_sent        = 0;
        src_idle_on       = 1'b1;
        sink_idle_on      = 1'b1;
        sink_hold_request = 0;
        parse_state       = SEEK_MARKER;
        marker_half       = 1'b0;
        seg_length        = '0;
        tables_remaining  = '0;
        coef_index        = '0;
        cur_table_id      = '0;
        cur_precision     = '0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_byte_in    <= 8'h00;
        s_stream_end <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_marker_scan();
        test_length_checks();
        test_stream_end();
        test_full_table_backpressure();
        test_random_streams();
        test_steady_stream();

        // Leave room for any stray result to show up.
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
